// File: hdl/assert_macros.svh
// Assertion macros for the center-of-mass four-velocity RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define CMV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted
`define CMV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hdl/cmv_pkg.sv
// Shared constants and types of the center-of-mass four-velocity block
`default_nettype none

package cmv_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 32;
	localparam int SUM_W      = 40;
	localparam int U_BITS     = 30;
	localparam int ROOT_STEPS = 32;
	localparam int RAD_W      = 2 * ROOT_STEPS;
	localparam int NUM_W      = FRAC_BITS + 32;
	localparam int QUO_W      = NUM_W;
	localparam int SQ_W       = 2 * SUM_W + 2;
	localparam int VEL_W      = FRAC_BITS + 62;
	localparam int ALU_W      = (SQ_W > VEL_W) ? SQ_W : VEL_W;
	localparam int CNT_W      = $clog2((NUM_W > SUM_W) ? NUM_W : SUM_W);
	localparam int STATUS_W   = 2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAST = 2'd2;

	typedef struct packed {
		logic        [SUM_W-1:0] energy;
		logic signed [SUM_W-1:0] px;
		logic signed [SUM_W-1:0] py;
		logic signed [SUM_W-1:0] pz;
	} sums_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

endpackage

`default_nettype wire

// File: hdl/cmv_alu.sv
// Shared wide adder/subtractor of the four-velocity sequencer
`default_nettype none

module cmv_alu (
	input  cmv_pkg::alu_req_t         req,
	output logic [cmv_pkg::ALU_W-1:0] res
);

	assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

`default_nettype wire

// File: hdl/cmv_accum.sv
// Saturating energy and momentum accumulators
`default_nettype none

module cmv_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                last_item,
	input  logic        [cmv_pkg::IN_W-1:0]     energy,
	input  logic signed [cmv_pkg::IN_W-1:0]     momentum_x,
	input  logic signed [cmv_pkg::IN_W-1:0]     momentum_y,
	input  logic signed [cmv_pkg::IN_W-1:0]     momentum_z,
	output cmv_pkg::sums_t                      sums_next
);

	localparam int SW = cmv_pkg::SUM_W;
	localparam int IW = cmv_pkg::IN_W;

	logic [SW-1:0] esum_q;
	logic [SW-1:0] px_q;
	logic [SW-1:0] py_q;
	logic [SW-1:0] pz_q;
	logic [SW:0]   esum_wide;

	function automatic logic [SW-1:0] add_sat(input logic [SW-1:0] a, input logic [IW-1:0] b);
		logic [SW:0] s;
		s = {a[SW-1], a} + {{(SW + 1 - IW){b[IW-1]}}, b};
		if (s[SW] != s[SW-1])
			return s[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		return s[SW-1:0];
	endfunction

	assign esum_wide        = {1'b0, esum_q} + {{(SW + 1 - IW){1'b0}}, energy};
	assign sums_next.energy = esum_wide[SW] ? {SW{1'b1}} : esum_wide[SW-1:0];
	assign sums_next.px     = add_sat(px_q, momentum_x);
	assign sums_next.py     = add_sat(py_q, momentum_y);
	assign sums_next.pz     = add_sat(pz_q, momentum_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q <= '0;
			px_q   <= '0;
			py_q   <= '0;
			pz_q   <= '0;
		end else if (accept) begin
			if (last_item) begin
				esum_q <= '0;
				px_q   <= '0;
				py_q   <= '0;
				pz_q   <= '0;
			end else begin
				esum_q <= sums_next.energy;
				px_q   <= sums_next.px;
				py_q   <= sums_next.py;
				pz_q   <= sums_next.pz;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/cmv_core.sv
// Sequencer and datapath registers computing gamma and gamma*u over a shared adder
`default_nettype none

`include "assert_macros.svh"

module cmv_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                capture,
	input  cmv_pkg::sums_t                      sums,
	output logic                                busy,
	output logic                                done,
	output logic        [cmv_pkg::OUT_W-1:0]    lorentz_factor,
	output logic signed [cmv_pkg::OUT_W-1:0]    velocity_x,
	output logic signed [cmv_pkg::OUT_W-1:0]    velocity_y,
	output logic signed [cmv_pkg::OUT_W-1:0]    velocity_z,
	output logic        [cmv_pkg::STATUS_W-1:0] status
);

	localparam int AW = cmv_pkg::ALU_W;
	localparam int SW = cmv_pkg::SUM_W;
	localparam int UB = cmv_pkg::U_BITS;
	localparam int QW = cmv_pkg::QUO_W;
	localparam int RW = cmv_pkg::RAD_W;
	localparam int OW = cmv_pkg::OUT_W;
	localparam int CW = cmv_pkg::CNT_W;
	localparam int MW = AW - 1 - UB;
	localparam logic [MW-1:0] NEG_LIM = MW'(1) << (OW - 1);
	localparam logic [MW-1:0] POS_LIM = NEG_LIM - MW'(1);
	localparam logic [AW-1:0] ONE_Q60 = AW'(1) << (2 * UB);

	typedef enum logic [8:0] {
		S_IDLE = 9'b0_0000_0001,
		S_SQ   = 9'b0_0000_0010,
		S_CHK  = 9'b0_0000_0100,
		S_DIV  = 9'b0_0000_1000,
		S_USQ  = 9'b0_0001_0000,
		S_PREP = 9'b0_0010_0000,
		S_ROOT = 9'b0_0100_0000,
		S_GDIV = 9'b0_1000_0000,
		S_VEL  = 9'b1_0000_0000
	} state_t;

	state_t                       state_q;
	logic [1:0]                   k_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                lim;
	logic [AW-1:0]                acc_q;
	logic [AW-1:0]                opa_q;
	logic [RW-1:0]                opb_q;
	logic [QW-1:0]                quo_q;
	logic [SW-1:0]                e_q;
	logic [SW-1:0]                mag_q [3];
	logic [2:0]                   neg_q;
	logic [UB-1:0]                u_q [3];
	logic [OW-1:0]                lorentz_q;
	logic [OW-1:0]                vel_q [3];
	logic [cmv_pkg::STATUS_W-1:0] status_q;
	logic                         done_q;

	cmv_pkg::alu_req_t            req;
	logic [AW-1:0]                res;
	logic [AW-1:0]                acc_mul;
	logic [AW-1:0]                acc_trial;
	logic [QW-1:0]                qn;
	logic [QW-1:0]                root;
	logic [OW-1:0]                gamma_sat;
	logic [OW-1:0]                vel_new;
	logic [SW-1:0]                mx;
	logic [SW-1:0]                my;
	logic [SW-1:0]                mz;
	logic                         ok;
	logic                         step_last;
	logic                         last_comp;

	function automatic logic [SW-1:0] mag(input logic [SW-1:0] v);
		return v[SW-1] ? (~v + SW'(1)) : v;
	endfunction

	function automatic logic [OW-1:0] sat_vel(input logic [MW-1:0] m, input logic neg);
		logic [MW-1:0] nm;
		nm = ~m + MW'(1);
		if (neg)
			return (m > NEG_LIM) ? NEG_LIM[OW-1:0] : nm[OW-1:0];
		return (m > POS_LIM) ? POS_LIM[OW-1:0] : m[OW-1:0];
	endfunction

	cmv_alu u_alu (
		.req (req),
		.res (res)
	);

	assign mx = mag(sums.px);
	assign my = mag(sums.py);
	assign mz = mag(sums.pz);

	always_comb begin
		req.a   = acc_q;
		req.b   = opa_q;
		req.sub = 1'b0;
		case (state_q)
			S_SQ: begin
				req.sub = (k_q == 2'd3);
			end
			S_DIV: begin
				req.a   = {acc_q[AW-2:0], 1'b0};
				req.b   = AW'(e_q);
				req.sub = 1'b1;
			end
			S_PREP: begin
				req.a   = ONE_Q60;
				req.b   = acc_q;
				req.sub = 1'b1;
			end
			S_ROOT: begin
				req.a   = {acc_q[AW-3:0], opb_q[RW-1 -: 2]};
				req.b   = AW'({quo_q, 2'b01});
				req.sub = 1'b1;
			end
			S_GDIV: begin
				req.a   = {acc_q[AW-2:0], (cnt_q == '0)};
				req.sub = 1'b1;
			end
			default: begin
				req.sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_SQ:                 lim = CW'(SW - 1);
			S_DIV, S_USQ, S_VEL:  lim = CW'(UB - 1);
			S_ROOT:               lim = CW'(cmv_pkg::ROOT_STEPS - 1);
			S_GDIV:               lim = CW'(cmv_pkg::NUM_W - 1);
			default:              lim = '0;
		endcase
	end

	assign step_last = (cnt_q == lim);
	assign last_comp = (state_q == S_SQ) ? (k_q == 2'd3) : (k_q == 2'd2);
	assign acc_mul   = opb_q[0] ? res : acc_q;
	assign ok        = ~res[AW-1];
	assign acc_trial = ok ? res : req.a;
	assign qn        = {quo_q[QW-2:0], ok};
	assign root      = (qn == '0) ? QW'(1) : qn;
	assign gamma_sat = (qn[QW-1:OW] != '0) ? {OW{1'b1}} : qn[OW-1:0];
	assign vel_new   = sat_vel(acc_mul[AW-2:UB], neg_q[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (capture) begin
						k_q   <= '0;
						cnt_q <= '0;
						if (sums.energy == '0)
							done_q <= 1'b1;
						else
							state_q <= S_SQ;
					end
				end
				S_SQ, S_DIV, S_USQ, S_VEL: begin
					if (step_last) begin
						cnt_q <= '0;
						if (last_comp) begin
							k_q <= '0;
							case (state_q)
								S_SQ:    state_q <= S_CHK;
								S_DIV:   state_q <= S_USQ;
								S_USQ:   state_q <= S_PREP;
								default: begin
									state_q <= S_IDLE;
									done_q  <= 1'b1;
								end
							endcase
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_CHK: begin
					if (!acc_q[AW-1]) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_PREP: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (step_last) begin
						cnt_q   <= '0;
						state_q <= S_GDIV;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_GDIV: begin
					if (step_last) begin
						cnt_q   <= '0;
						state_q <= S_VEL;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (capture) begin
					e_q      <= sums.energy;
					mag_q[0] <= mx;
					mag_q[1] <= my;
					mag_q[2] <= mz;
					neg_q    <= {sums.pz[SW-1], sums.py[SW-1], sums.px[SW-1]};
					acc_q    <= '0;
					opa_q    <= AW'(mx);
					opb_q    <= RW'(mx);
					if (sums.energy == '0) begin
						lorentz_q <= '0;
						vel_q[0]  <= '0;
						vel_q[1]  <= '0;
						vel_q[2]  <= '0;
						status_q  <= cmv_pkg::ST_ZERO;
					end
				end
			end
			S_SQ: begin
				acc_q <= acc_mul;
				opa_q <= opa_q << 1;
				opb_q <= opb_q >> 1;
				if (step_last && !last_comp) begin
					mag_q[0] <= mag_q[1];
					mag_q[1] <= mag_q[2];
					mag_q[2] <= mag_q[0];
					if (k_q == 2'd2) begin
						opa_q <= AW'(e_q);
						opb_q <= RW'(e_q);
					end else begin
						opa_q <= AW'(mag_q[1]);
						opb_q <= RW'(mag_q[1]);
					end
				end
			end
			S_CHK: begin
				if (!acc_q[AW-1]) begin
					lorentz_q <= '0;
					vel_q[0]  <= '0;
					vel_q[1]  <= '0;
					vel_q[2]  <= '0;
					status_q  <= cmv_pkg::ST_FAST;
				end else begin
					acc_q <= AW'(mag_q[0]);
					quo_q <= '0;
				end
			end
			S_DIV: begin
				acc_q <= acc_trial;
				quo_q <= qn;
				if (step_last) begin
					u_q[2]   <= qn[UB-1:0];
					u_q[1]   <= u_q[2];
					u_q[0]   <= u_q[1];
					mag_q[0] <= mag_q[1];
					mag_q[1] <= mag_q[2];
					mag_q[2] <= mag_q[0];
					acc_q    <= AW'(mag_q[1]);
					quo_q    <= '0;
					if (last_comp) begin
						acc_q <= '0;
						opa_q <= AW'(u_q[1]);
						opb_q <= RW'(u_q[1]);
					end
				end
			end
			S_USQ: begin
				acc_q <= acc_mul;
				opa_q <= opa_q << 1;
				opb_q <= opb_q >> 1;
				if (step_last) begin
					u_q[0] <= u_q[1];
					u_q[1] <= u_q[2];
					u_q[2] <= u_q[0];
					opa_q  <= AW'(u_q[1]);
					opb_q  <= RW'(u_q[1]);
				end
			end
			S_PREP: begin
				opb_q <= {res[RW-3:0], 2'b00};
				acc_q <= '0;
				quo_q <= '0;
			end
			S_ROOT: begin
				acc_q <= acc_trial;
				quo_q <= qn;
				opb_q <= opb_q << 2;
				if (step_last) begin
					opa_q <= AW'(root);
					acc_q <= '0;
					quo_q <= '0;
				end
			end
			S_GDIV: begin
				acc_q <= acc_trial;
				quo_q <= qn;
				if (step_last) begin
					lorentz_q <= gamma_sat;
					acc_q     <= '0;
					opa_q     <= AW'(qn);
					opb_q     <= RW'(u_q[0]);
				end
			end
			S_VEL: begin
				acc_q <= acc_mul;
				opa_q <= opa_q << 1;
				opb_q <= opb_q >> 1;
				if (step_last) begin
					vel_q[2] <= vel_new;
					vel_q[1] <= vel_q[2];
					vel_q[0] <= vel_q[1];
					u_q[0]   <= u_q[1];
					u_q[1]   <= u_q[2];
					u_q[2]   <= u_q[0];
					neg_q    <= {neg_q[0], neg_q[2:1]};
					acc_q    <= '0;
					opa_q    <= AW'(quo_q);
					opb_q    <= RW'(u_q[1]);
					if (last_comp)
						status_q <= cmv_pkg::ST_OK;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign lorentz_factor = lorentz_q;
	assign velocity_x     = vel_q[0];
	assign velocity_y     = vel_q[1];
	assign velocity_z     = vel_q[2];
	assign status         = status_q;

	`CMV_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE,
		"result strobe while busy")
	`CMV_ASSERT_IMP(a_busy_cause, clk, arst_n, $rose(state_q != S_IDLE), $past(capture),
		"busy without a last transaction")
	`CMV_ASSERT_IMP(a_flag_zeros, clk, arst_n, done_q && status_q != cmv_pkg::ST_OK,
		lorentz_q == '0 && vel_q[0] == '0 && vel_q[1] == '0 && vel_q[2] == '0,
		"flagged result not zero")
	`CMV_ASSERT_IMP(a_fast_path, clk, arst_n, done_q && status_q == cmv_pkg::ST_FAST,
		$past(state_q == S_CHK), "speed flag outside the light check")

endmodule

`default_nettype wire

// File: hdl/center_of_mass_four_velocity.sv
// Top level of the center-of-mass four-velocity block
// A transaction is taken on start while busy is low. An item not marked last is folded into
// saturating 40-bit sums and busy stays low, so such items may come every cycle.
// The item marked last drops the sums into a sequencer that runs one shared 82-bit
// adder/subtractor one bit per cycle: four 40-bit squares for the light-speed test, three
// 30-bit divides, three 30-bit squares, a 32-step root, a 48-step reciprocal and three
// 30-bit scalings. The result appears with done high for exactly one cycle, the cycle in
// which busy falls; a zero total energy gives its result in the cycle after the last item,
// a speed not below light right after the light-speed test.
// The receiver cannot stall: take the result in the cycle that done is high or lose it.
`default_nettype none

module center_of_mass_four_velocity (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic        [cmv_pkg::IN_W-1:0]     energy,
	input  logic signed [cmv_pkg::IN_W-1:0]     momentum_x,
	input  logic signed [cmv_pkg::IN_W-1:0]     momentum_y,
	input  logic signed [cmv_pkg::IN_W-1:0]     momentum_z,
	input  logic                                last_item,
	output logic                                done,
	output logic        [cmv_pkg::OUT_W-1:0]    lorentz_factor,
	output logic signed [cmv_pkg::OUT_W-1:0]    velocity_x,
	output logic signed [cmv_pkg::OUT_W-1:0]    velocity_y,
	output logic signed [cmv_pkg::OUT_W-1:0]    velocity_z,
	output logic        [cmv_pkg::STATUS_W-1:0] status
);

	logic           accept;
	logic           capture;
	cmv_pkg::sums_t sums_next;

	assign accept  = start & ~busy;
	assign capture = accept & last_item;

	cmv_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.last_item  (last_item),
		.energy     (energy),
		.momentum_x (momentum_x),
		.momentum_y (momentum_y),
		.momentum_z (momentum_z),
		.sums_next  (sums_next)
	);

	cmv_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.capture        (capture),
		.sums           (sums_next),
		.busy           (busy),
		.done           (done),
		.lorentz_factor (lorentz_factor),
		.velocity_x     (velocity_x),
		.velocity_y     (velocity_y),
		.velocity_z     (velocity_z),
		.status         (status)
	);

endmodule

`default_nettype wire
